>>> hw/rtl/smp_pkg.sv
// ----------------------------------------------------------------------------
// smp_pkg
// Shared types and constants of the square matrix power block.
// ----------------------------------------------------------------------------
package smp_pkg;

  // element width of the matrix arithmetic
  localparam int unsigned ELEM_W      = 32;
  localparam int unsigned DEF_MAX_DIM = 8;
  localparam int unsigned IDX_W       = 3;
  localparam int unsigned SIZE_W      = 4;
  localparam int unsigned POWER_W     = 31;
  localparam int unsigned BANK_W      = 2;

  // memory banks: the loaded matrix and three working matrices
  localparam logic [BANK_W-1:0] BANK_BASE = 2'd0;
  localparam logic [BANK_W-1:0] BANK_W1   = 2'd1;
  localparam logic [BANK_W-1:0] BANK_W2   = 2'd2;

  typedef struct packed {
    logic        [IDX_W-1:0]   row_index;
    logic        [IDX_W-1:0]   col_index;
    logic signed [31:0]        element_value;
    logic        [POWER_W-1:0] power;
    logic                      load_done;
  } smp_in_t;

  typedef struct packed {
    logic        [IDX_W-1:0] out_row;
    logic        [IDX_W-1:0] out_col;
    logic signed [31:0]      out_value;
    logic                    out_last;
  } smp_out_t;

  // structured memory address, flattened inside the memory
  typedef struct packed {
    logic [BANK_W-1:0] bank;
    logic [IDX_W-1:0]  row;
    logic [IDX_W-1:0]  col;
  } smp_addr_t;

  // one product term travelling down the multiply-accumulate pipeline
  typedef struct packed {
    logic      valid;
    logic      first;
    logic      last;
    logic      a_ident;
    logic      diag;
    smp_addr_t waddr;
  } smp_tok_t;

endpackage

>>> hw/rtl/smp_mem.sv
// ----------------------------------------------------------------------------
// smp_mem
// Matrix element memory: four banks, one write port, two registered reads.
// ----------------------------------------------------------------------------
module smp_mem
  import smp_pkg::*;
#(
  parameter int unsigned MAX_DIM = DEF_MAX_DIM
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  smp_addr_t         waddr_i,
  input  logic [ELEM_W-1:0] wdata_i,
  input  smp_addr_t         ra_addr_i,
  input  smp_addr_t         rb_addr_i,
  output logic [ELEM_W-1:0] ra_data_o,
  output logic [ELEM_W-1:0] rb_data_o
);

  localparam int unsigned CELLS  = MAX_DIM * MAX_DIM;
  localparam int unsigned DEPTH  = (1 << BANK_W) * CELLS;
  localparam int unsigned ADDR_W = $clog2(DEPTH);

  logic [ELEM_W-1:0] ram_q [DEPTH];

  function automatic logic [ADDR_W-1:0] flat(smp_addr_t a);
    int unsigned lin;
    lin  = int'(a.bank) * CELLS + int'(a.row) * MAX_DIM + int'(a.col);
    flat = ADDR_W'(lin);
  endfunction

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      ram_q[flat(waddr_i)] <= wdata_i;
    end
    ra_data_o <= ram_q[flat(ra_addr_i)];
    rb_data_o <= ram_q[flat(rb_addr_i)];
  end

endmodule

>>> hw/rtl/smp_mac.sv
// ----------------------------------------------------------------------------
// smp_mac
// Pipelined multiply-accumulate producing one dot product per element.
// ----------------------------------------------------------------------------
module smp_mac
  import smp_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  smp_tok_t          tok_i,
  input  logic [ELEM_W-1:0] a_data_i,
  input  logic [ELEM_W-1:0] b_data_i,
  output logic              we_o,
  output smp_addr_t         waddr_o,
  output logic [ELEM_W-1:0] wdata_o,
  output logic              busy_o
);

  smp_tok_t            s1_q, s2_q;
  logic [ELEM_W-1:0]   a_val;
  logic [ELEM_W-1:0]   full;
  logic [ELEM_W-1:0]   prod_q;
  logic [ELEM_W-1:0]   acc_q;
  logic [ELEM_W-1:0]   sum;

  // identity operand is made up on the fly
  always_comb begin
    if (s1_q.a_ident) begin
      a_val = s1_q.diag ? ELEM_W'(1) : '0;
    end else begin
      a_val = a_data_i;
    end
    full = a_val * b_data_i;
  end

  assign sum = s2_q.first ? prod_q : acc_q + prod_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= '0;
      s2_q <= '0;
    end else begin
      s1_q <= tok_i;
      s2_q <= s1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= full;
    if (s2_q.valid) begin
      acc_q <= sum;
    end
  end

  assign we_o    = s2_q.valid & s2_q.last;
  assign waddr_o = s2_q.waddr;
  assign wdata_o = sum;
  assign busy_o  = s1_q.valid | s2_q.valid;

endmodule

>>> hw/rtl/square_matrix_power.sv
// ----------------------------------------------------------------------------
// square_matrix_power
// Raises a loaded square matrix to an integer power by square-and-multiply.
// ----------------------------------------------------------------------------
// Elements are loaded one word per cycle while the block is idle; the word
// with load_done set also carries the exponent and starts a run. During a
// run the input is stalled. Each matrix product of size n runs through the
// single shared multiply-accumulate (one product term per cycle, set by the
// two memory read ports), then the pipeline drains and the banks are
// renamed. Every set exponent bit costs one product, every exponent bit
// below the top one costs a squaring, and each exponent bit passes through
// a decision step that picks the next product. Each result word passes
// through a read, a capture and a wait state, and the next word is not read
// until the current one is taken. Results leave row-major with out_last on
// the final word. Arithmetic wraps at 32 bits; an exponent of zero gives
// the identity. Matrices live in one memory of four banks: the loaded
// matrix is kept across runs, and the running result, square and scratch
// matrices are renamed rather than copied.
// ----------------------------------------------------------------------------
module square_matrix_power
  import smp_pkg::*;
#(
  parameter int unsigned MAX_DIM = DEF_MAX_DIM
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [SIZE_W-1:0] cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  smp_in_t           in_word_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output smp_out_t          out_word_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_ISSUE,
    ST_DRAIN,
    ST_ADVANCE,
    ST_OUT_RD,
    ST_OUT_CAP,
    ST_OUT_WAIT
  } state_e;

  localparam logic [SIZE_W-1:0] MAX_DIM_W = SIZE_W'(MAX_DIM);

  state_e             state_q;
  logic [SIZE_W-1:0]  size_q;
  logic [IDX_W-1:0]   i_q, j_q, k_q, nm1_q;
  logic [POWER_W-1:0] exp_q;
  logic [BANK_W-1:0]  r_sel_q, s_sel_q, t_sel_q;
  logic               r_ident_q;   // result still the identity
  logic               op_sq_q;     // current product is a squaring
  logic               out_valid_q;
  smp_out_t           out_word_q;

  logic [SIZE_W-1:0]  dim;
  logic               in_accept;
  logic               load_we;
  logic               i_end, j_end, k_end;
  logic               out_last;

  smp_tok_t           tok;
  smp_addr_t          ra_addr, rb_addr, wr_addr;
  logic [ELEM_W-1:0]  ra_data, rb_data, wr_data;
  logic               wr_en;
  logic               mac_we;
  smp_addr_t          mac_waddr;
  logic [ELEM_W-1:0]  mac_wdata;
  logic               mac_busy;

  // size in use, clamped to the supported range
  always_comb begin
    if (size_q == '0) begin
      dim = SIZE_W'(1);
    end else if (size_q > MAX_DIM_W) begin
      dim = MAX_DIM_W;
    end else begin
      dim = size_q;
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i & ~in_stall_o;
  // elements beyond the memory are dropped
  assign load_we    = in_accept &
                      ({1'b0, in_word_i.row_index} < MAX_DIM_W) &
                      ({1'b0, in_word_i.col_index} < MAX_DIM_W);

  assign i_end    = (i_q == nm1_q);
  assign j_end    = (j_q == nm1_q);
  assign k_end    = (k_q == nm1_q);
  assign out_last = i_end & j_end;

  // product term issued this cycle
  always_comb begin
    tok.valid      = (state_q == ST_ISSUE);
    tok.first      = (k_q == '0);
    tok.last       = k_end;
    tok.a_ident    = r_ident_q & ~op_sq_q;
    tok.diag       = (i_q == k_q);
    tok.waddr.bank = t_sel_q;
    tok.waddr.row  = i_q;
    tok.waddr.col  = j_q;
  end

  // read ports: left operand row by column, right operand column walk
  always_comb begin
    if (state_q == ST_OUT_RD || state_q == ST_OUT_CAP || state_q == ST_OUT_WAIT) begin
      ra_addr.bank = r_sel_q;
      ra_addr.row  = i_q;
      ra_addr.col  = j_q;
    end else begin
      ra_addr.bank = op_sq_q ? s_sel_q : r_sel_q;
      ra_addr.row  = i_q;
      ra_addr.col  = k_q;
    end
    rb_addr.bank = s_sel_q;
    rb_addr.row  = k_q;
    rb_addr.col  = j_q;
  end

  // write port: loads only happen while idle, so no clash with the mac
  always_comb begin
    if (mac_we) begin
      wr_addr = mac_waddr;
      wr_data = mac_wdata;
    end else begin
      wr_addr.bank = BANK_BASE;
      wr_addr.row  = in_word_i.row_index;
      wr_addr.col  = in_word_i.col_index;
      wr_data      = ELEM_W'(in_word_i.element_value);
    end
    wr_en = mac_we | load_we;
  end

  smp_mem #(
    .MAX_DIM (MAX_DIM)
  ) u_mem (
    .clk_i     (clk_i),
    .we_i      (wr_en),
    .waddr_i   (wr_addr),
    .wdata_i   (wr_data),
    .ra_addr_i (ra_addr),
    .rb_addr_i (rb_addr),
    .ra_data_o (ra_data),
    .rb_data_o (rb_data)
  );

  smp_mac u_mac (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .tok_i    (tok),
    .a_data_i (ra_data),
    .b_data_i (rb_data),
    .we_o     (mac_we),
    .waddr_o  (mac_waddr),
    .wdata_o  (mac_wdata),
    .busy_o   (mac_busy)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      size_q      <= SIZE_W'(8);
      i_q         <= '0;
      j_q         <= '0;
      k_q         <= '0;
      nm1_q       <= '0;
      exp_q       <= '0;
      r_sel_q     <= BANK_W1;
      s_sel_q     <= BANK_BASE;
      t_sel_q     <= BANK_W2;
      r_ident_q   <= 1'b1;
      op_sq_q     <= 1'b0;
      out_valid_q <= 1'b0;
      out_word_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        size_q <= cfg_wdata_i;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_accept && in_word_i.load_done) begin
            exp_q     <= in_word_i.power;
            nm1_q     <= IDX_W'(dim - SIZE_W'(1));
            r_sel_q   <= BANK_W1;
            s_sel_q   <= BANK_BASE;
            t_sel_q   <= BANK_W2;
            r_ident_q <= 1'b1;
            state_q   <= ST_DECIDE;
          end
        end
        ST_DECIDE: begin
          i_q <= '0;
          j_q <= '0;
          k_q <= '0;
          if (exp_q == '0) begin
            state_q <= ST_OUT_RD;
          end else begin
            op_sq_q <= ~exp_q[0];
            state_q <= ST_ISSUE;
          end
        end
        ST_ISSUE: begin
          if (k_end) begin
            k_q <= '0;
            if (j_end) begin
              j_q <= '0;
              if (i_end) begin
                i_q     <= '0;
                state_q <= ST_DRAIN;
              end else begin
                i_q <= i_q + IDX_W'(1);
              end
            end else begin
              j_q <= j_q + IDX_W'(1);
            end
          end else begin
            k_q <= k_q + IDX_W'(1);
          end
        end
        ST_DRAIN: begin
          // wait for the last dot product to be written back
          if (!mac_busy) begin
            state_q <= ST_ADVANCE;
          end
        end
        ST_ADVANCE: begin
          if (op_sq_q) begin
            // new square is in scratch; the loaded bank is never reused
            s_sel_q <= t_sel_q;
            t_sel_q <= (s_sel_q == BANK_BASE) ? (r_sel_q ^ t_sel_q) : s_sel_q;
            exp_q   <= exp_q >> 1;
            state_q <= ST_DECIDE;
          end else begin
            r_sel_q   <= t_sel_q;
            t_sel_q   <= r_sel_q;
            r_ident_q <= 1'b0;
            if (exp_q[POWER_W-1:1] == '0) begin
              // top bit done, the final squaring is not needed
              state_q <= ST_OUT_RD;
            end else begin
              op_sq_q <= 1'b1;
              state_q <= ST_ISSUE;
            end
          end
        end
        ST_OUT_RD: begin
          state_q <= ST_OUT_CAP;
        end
        ST_OUT_CAP: begin
          out_word_q.out_row  <= i_q;
          out_word_q.out_col  <= j_q;
          if (r_ident_q) begin
            out_word_q.out_value <= (i_q == j_q) ? 32'sd1 : 32'sd0;
          end else begin
            out_word_q.out_value <= $signed(ra_data[31:0]);
          end
          out_word_q.out_last <= out_last;
          out_valid_q         <= 1'b1;
          state_q             <= ST_OUT_WAIT;
        end
        ST_OUT_WAIT: begin
          if (!out_stall_i) begin
            out_valid_q <= 1'b0;
            if (out_last) begin
              i_q     <= '0;
              j_q     <= '0;
              state_q <= ST_IDLE;
            end else begin
              if (j_end) begin
                j_q <= '0;
                i_q <= i_q + IDX_W'(1);
              end else begin
                j_q <= j_q + IDX_W'(1);
              end
              state_q <= ST_OUT_RD;
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

>>> tb/sv/square_matrix_power_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// square_matrix_power_test
// Self-checking bench for the square matrix power block: a queue-fed driver
// loads matrices and exponents under random bursts, a monitor stalls the
// result side and compares every result word with a local prediction.
// ----------------------------------------------------------------------------
module square_matrix_power_test;
  import smp_pkg::*;

  localparam int QUIET_LIMIT = 100000;  // cycles with no handshake at all
  localparam int HOLD_CYCLES = 600;     // long receiver hold-off

  typedef logic [ELEM_W-1:0] mat_t [DEF_MAX_DIM][DEF_MAX_DIM];

  // clock, reset and block inputs, all known from time zero
  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              cfg_we_i    = 1'b0;
  logic [SIZE_W-1:0] cfg_wdata_i = '0;
  logic              in_valid_i  = 1'b0;
  smp_in_t           in_word_i   = '0;
  logic              out_stall_i = 1'b0;
  logic              in_stall_o;
  logic              out_valid_o;
  smp_out_t          out_word_o;

  // predictor state: its own copy of the loaded matrix and the size register
  mat_t              stored_matrix;
  logic [SIZE_W-1:0] size_setting = 4'd8;

  smp_in_t  words_pending[$];      // load words not yet offered
  smp_out_t result_words_due[$];   // predicted result words, oldest first
  bit       cell_loaded [DEF_MAX_DIM][DEF_MAX_DIM];
  int       queued_words;
  int       failures;
  int       checked_words;

  // sender burst state
  int burst_left;
  int gap_left;

  // receiver stall state
  int       hold_left;
  bit       hold_done;
  int       stall_style;
  int       style_age;
  bit       stall_next;
  smp_out_t want;

  int quiet_cycles;

  always #2 clk_i = ~clk_i;

  square_matrix_power #(
    .MAX_DIM(DEF_MAX_DIM)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_word_i  (in_word_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_word_o (out_word_o)
  );

  // size register as the block sees it: zero means one, above max means max
  function automatic int dim_of(input logic [SIZE_W-1:0] raw);
    if (raw == 0) return 1;
    if (raw > DEF_MAX_DIM) return DEF_MAX_DIM;
    return int'(raw);
  endfunction

  // p = a * b over the top-left n x n corner, wrapping at the element width
  function automatic void matrix_product(output mat_t p, input mat_t a, input mat_t b,
                                         input int n);
    logic [ELEM_W-1:0] acc;
    p = a;
    for (int r = 0; r < n; r++) begin
      for (int c = 0; c < n; c++) begin
        acc = '0;
        for (int k = 0; k < n; k++) acc += a[r][k] * b[k][c];
        p[r][c] = acc;
      end
    end
  endfunction

  // store the element; on the closing word raise the matrix to the power
  task automatic absorb_in_word(input smp_in_t w);
    mat_t               running;
    mat_t               square;
    mat_t               scratch;
    logic [POWER_W-1:0] bits_left;
    smp_out_t           due;
    int                 n;
    stored_matrix[w.row_index][w.col_index] = w.element_value;
    if (!w.load_done) return;
    n = dim_of(size_setting);
    for (int r = 0; r < DEF_MAX_DIM; r++) begin
      for (int c = 0; c < DEF_MAX_DIM; c++) begin
        running[r][c] = (r == c) ? 1 : 0;
        square[r][c]  = stored_matrix[r][c];
      end
    end
    // square-and-multiply from the low exponent bit
    bits_left = w.power;
    while (bits_left != 0) begin
      if (bits_left[0]) begin
        matrix_product(scratch, running, square, n);
        running = scratch;
      end
      matrix_product(scratch, square, square, n);
      square = scratch;
      bits_left >>= 1;
    end
    // row-major, last mark on the bottom-right element
    for (int r = 0; r < n; r++) begin
      for (int c = 0; c < n; c++) begin
        due.out_row   = IDX_W'(r);
        due.out_col   = IDX_W'(c);
        due.out_value = running[r][c];
        due.out_last  = (r == n - 1) && (c == n - 1);
        result_words_due.push_back(due);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // driver: bursts of random length, random gaps, payload held while stalled
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_word_i  <= '0;
      burst_left = 0;
      gap_left   = 0;
    end else begin
      if (in_valid_i && !in_stall_o) absorb_in_word(in_word_i);
      // free to move on once the current word is gone or none is offered
      if (!in_valid_i || !in_stall_o) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (words_pending.size() > 0) begin
          in_valid_i <= 1'b1;
          in_word_i  <= words_pending.pop_front();
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            // new burst; a quarter of bursts follow on with no gap at all
            burst_left = $urandom_range(0, 12);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: checks each accepted result word, then picks the next stall
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      hold_left   = 0;
      hold_done   = 1'b0;
      stall_style = 0;
      style_age   = 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        checked_words++;
        if (result_words_due.size() == 0) begin
          failures++;
          if (failures <= 10)
            $display("unexpected result word: row %0d col %0d value %0d last %0b",
                     out_word_o.out_row, out_word_o.out_col, out_word_o.out_value,
                     out_word_o.out_last);
        end else begin
          want = result_words_due.pop_front();
          if (out_word_o.out_row !== want.out_row || out_word_o.out_col !== want.out_col ||
              out_word_o.out_value !== want.out_value ||
              out_word_o.out_last !== want.out_last) begin
            failures++;
            if (failures <= 10)
              $display("result mismatch: expected row %0d col %0d value %0d last %0b, %s",
                       want.out_row, want.out_col, want.out_value, want.out_last,
                       $sformatf("got row %0d col %0d value %0d last %0b",
                                 out_word_o.out_row, out_word_o.out_col,
                                 out_word_o.out_value, out_word_o.out_last));
          end
        end
      end

      // one long hold-off, well into the random traffic, while words are still
      // waiting to go in, so the input backs up
      if (hold_left > 0) begin
        hold_left--;
      end else if (!hold_done && checked_words >= 100 && words_pending.size() != 0) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end

      // stall pattern periodically picks a new random character
      style_age++;
      if (style_age % 64 == 0) stall_style = $urandom_range(0, 3);
      case (stall_style)
        0:       stall_next = 1'b0;
        1:       stall_next = ($urandom_range(0, 3) == 0);
        2:       stall_next = ($urandom_range(0, 3) != 0);
        default: stall_next = style_age[1];
      endcase
      out_stall_i <= (hold_left > 0) || stall_next;
    end
  end

  // ---------------------------------------------------------------------------
  // watchdog: too long without any handshake ends the run
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i)
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic queue_word(input int row, input int col, input logic [31:0] value,
                            input logic [POWER_W-1:0] power, input bit done);
    smp_in_t w;
    w.row_index     = IDX_W'(row);
    w.col_index     = IDX_W'(col);
    w.element_value = value;
    w.power         = power;
    w.load_done     = done;
    words_pending.push_back(w);
    cell_loaded[row][col] = 1'b1;
    queued_words++;
  endtask

  // size register written only while the block is idle
  task automatic write_size(input logic [SIZE_W-1:0] raw);
    @(posedge clk_i);
    cfg_we_i     <= 1'b1;
    cfg_wdata_i  <= raw;
    size_setting = raw;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // wait for every word to go in and every result to come out
  task automatic settle(input int extra);
    do @(negedge clk_i);
    while (words_pending.size() != 0 || in_valid_i || result_words_due.size() != 0);
    repeat (extra) @(posedge clk_i);
  endtask

  // mix of extremes, small values that keep products readable, and full range
  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 9))
      0:          return 32'h7fff_ffff;
      1:          return 32'h8000_0000;
      2, 3, 4, 5: return 32'($signed($urandom_range(0, 6)) - 3);
      default:    return $urandom();
    endcase
  endfunction

  // exponent sized so that big matrices stay quick
  function automatic logic [POWER_W-1:0] pick_power(input int n);
    int top;
    top = (n <= 5) ? 255 : 15;
    case ($urandom_range(0, 9))
      0, 1:       return POWER_W'($urandom_range(0, 3));
      2, 3, 4, 5: return POWER_W'($urandom_range(4, top));
      default:    return (n <= 3) ? POWER_W'($urandom()) : POWER_W'($urandom_range(0, top));
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin
    logic [SIZE_W-1:0] size_plan [16];
    logic [SIZE_W-1:0] raw;
    int                n;
    int                plan_pos;
    int                word_goal;
    int                phase_start;
    int                count;
    size_plan = '{4'd3, 4'd1, 4'd8, 4'd0, 4'd2, 4'd15, 4'd4, 4'd2,
                  4'd5, 4'd9, 4'd3, 4'd6, 4'd1, 4'd7, 4'd2, 4'd12};

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: 2x2 with extreme elements
    write_size(4'd2);
    queue_word(0, 0, 32'h7fff_ffff, '1, 1'b0);
    queue_word(0, 1, 32'h8000_0000, '0, 1'b0);
    queue_word(1, 0, 32'hffff_ffff, 31'h2aaa_aaaa, 1'b0);
    queue_word(1, 1, 32'h0000_0000, '0, 1'b1);           // zero exponent: identity
    queue_word(7, 7, 32'd5, '0, 1'b0);                   // outside the size in use
    queue_word(1, 1, 32'd3, 31'd1, 1'b1);                // power one: the matrix itself
    queue_word(0, 0, 32'd2, 31'd2, 1'b1);
    queue_word(0, 1, 32'd1, 31'h7fff_ffff, 1'b1);        // largest exponent
    queue_word(1, 0, 32'd5, 31'h5555_5555, 1'b1);
    settle(8);
    // size zero behaves as one
    write_size(4'd0);
    queue_word(0, 0, 32'hffff_fffd, 31'h7fff_ffff, 1'b1);
    queue_word(0, 0, 32'h8000_0000, 31'd3, 1'b1);
    settle(8);
    write_size(4'd1);
    queue_word(3, 5, 32'd9, '0, 1'b0);
    queue_word(0, 0, 32'd7, 31'd13, 1'b1);
    queue_word(0, 0, 32'd0, 31'h4000_0000, 1'b1);        // zero matrix, big power

    // random phases, one size setting each
    word_goal = queued_words + 300;
    plan_pos  = 0;
    while (queued_words < word_goal) begin
      raw = size_plan[plan_pos % 16];
      plan_pos++;
      settle(8);
      write_size(raw);
      n = dim_of(raw);
      phase_start = queued_words;
      // never let a run read an element that was not loaded
      for (int r = 0; r < n; r++)
        for (int c = 0; c < n; c++)
          if (!cell_loaded[r][c])
            queue_word(r, c, pick_value(), POWER_W'($urandom()), 1'b0);
      do begin
        case ($urandom_range(0, 9))
          0, 1: begin
            // full reload of the matrix in use
            for (int r = 0; r < n; r++)
              for (int c = 0; c < n; c++)
                queue_word(r, c, pick_value(), POWER_W'($urandom()), 1'b0);
          end
          2, 3: begin
            // noise anywhere in the store, inside or outside the size
            count = $urandom_range(1, 4);
            repeat (count)
              queue_word($urandom_range(0, DEF_MAX_DIM - 1), $urandom_range(0, DEF_MAX_DIM - 1),
                         pick_value(), POWER_W'($urandom()), 1'b0);
          end
          default: begin
            // a few updates inside the size in use
            count = $urandom_range(0, 3);
            repeat (count)
              queue_word($urandom_range(0, n - 1), $urandom_range(0, n - 1), pick_value(),
                         POWER_W'($urandom()), 1'b0);
          end
        endcase
        queue_word($urandom_range(0, n - 1), $urandom_range(0, n - 1), pick_value(),
                   pick_power(n), 1'b1);
      end while (queued_words - phase_start < 20);
    end

    settle(20);
    if (failures == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
